// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/mcst_pkg.sv
// Package: types, constants and codes of the subflow table.
`timescale 1ns / 1ps
`default_nettype none
package mcst_pkg;
  localparam int TableEntries = 64;
  localparam int MaxSubflows  = 8;

  typedef enum logic [1:0] {
    ACT_ESTABLISH = 2'd0,
    ACT_SUB_EST   = 2'd1,
    ACT_CLOSE     = 2'd2,
    ACT_SUB_CLOSE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_MISSING = 3'd3,
    ST_LIST    = 3'd4,
    ST_NOFLOW  = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        is_ipv6;
    logic [63:0] conn_key;
    logic [63:0] subflow_id;
    logic [15:0] rem_port;
    logic [15:0] loc_port;
    logic [31:0] rem_ip;
    logic [31:0] loc_ip;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] subflow_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_KREQ, S_KCHK, S_DECIDE, S_FREQ, S_FCHK, S_SREQ, S_SMOVE, S_DONE
  } state_e;
endpackage
`default_nettype wire

// File: src/mcst_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mcst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: src/multipath_connection_subflow_table.sv
// Top level: connection table with per-connection subflow lists.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  A command word (cmd_i) is taken at a clock edge where start_i is high and
//  busy_o is low. Exactly one response word follows on rsp_o, marked by
//  done_o for one cycle; the receiver cannot stall, so it must take it.
//  The key search walks the entry table one entry at a time, each entry an
//  address step then a compare on registered read data, and stops at a hit
//  or after TABLE_ENTRIES entries. A decide state and the done state follow.
//  Subflow close adds a read and compare per slot compared and a read and
//  write per slot shifted down, over at most MAX_SUBFLOWS slots. IPv6 words
//  skip the search and go straight to the done state. One command at a time.
//  busy_o drops in the idle state after done_o, so a new word is taken only
//  after the last one is done. The entry memory's single port sets the pace.
//  Reset clears the valid bits (flip-flops) and the controller; key, count
//  and subflow memories are undefined until written and never read before.
module multipath_connection_subflow_table #(
  parameter int TABLE_ENTRIES = mcst_pkg::TableEntries,
  parameter int MAX_SUBFLOWS  = mcst_pkg::MaxSubflows
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire mcst_pkg::cmd_t cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output mcst_pkg::rsp_t      rsp_o
);
  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW = $clog2(MAX_SUBFLOWS);
  localparam int FD = TABLE_ENTRIES * MAX_SUBFLOWS;
  localparam int FW = $clog2(FD);
  localparam int CW = SW + 1;
  localparam int DW = 64 + 32 + 64;

  mcst_pkg::state_e state_q, state_d;
  mcst_pkg::cmd_t   cmd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [EW:0]  idx_q, idx_d;     // entry walk counter
  logic [EW-1:0] ent_q, ent_d;    // found entry
  logic         found_q, found_d;
  logic [CW-1:0] cnt_q, cnt_d;    // stored count of found entry
  logic [SW:0]  sl_q, sl_d;       // slot walk counter
  logic [2:0]   st_q, st_d;
  logic [3:0]   rc_q, rc_d;

  // entry memory: key plus count
  logic          ew_we;
  logic [EW-1:0] ew_addr;
  logic [64+CW-1:0] ew_wd, ew_rd;
  logic          fw_we;
  logic [FW-1:0] fw_addr;
  logic [DW-1:0] fw_wd, fw_rd;

  mcst_ram #(.Width(64 + CW), .Depth(1 << EW)) u_ent (
    .clk_i, .we_i(ew_we), .addr_i(ew_addr), .wdata_i(ew_wd), .rdata_o(ew_rd)
  );
  mcst_ram #(.Width(DW), .Depth(1 << FW)) u_flow (
    .clk_i, .we_i(fw_we), .addr_i(fw_addr), .wdata_i(fw_wd), .rdata_o(fw_rd)
  );

  logic [DW-1:0] new_flow;
  assign new_flow = {cmd_q.subflow_id, cmd_q.rem_port,
                     cmd_q.loc_port[7:0], cmd_q.loc_port[15:8],
                     cmd_q.rem_ip, cmd_q.loc_ip};

  logic [EW-1:0] idx_e;
  assign idx_e = idx_q[EW-1:0];
  logic [SW-1:0] next_sl;
  assign next_sl = cnt_q[SW-1:0];
  logic [CW-1:0] lim;
  assign lim = (cnt_q > CW'(MAX_SUBFLOWS)) ? CW'(MAX_SUBFLOWS) : cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcst_pkg::S_IDLE:   if (start_i) state_d = cmd_i.is_ipv6 ? mcst_pkg::S_DONE
                                                               : mcst_pkg::S_KREQ;
      mcst_pkg::S_KREQ:   state_d = mcst_pkg::S_KCHK;
      mcst_pkg::S_KCHK:   if (found_d || idx_q + 1'b1 >= (EW+1)'(TABLE_ENTRIES))
                            state_d = mcst_pkg::S_DECIDE;
                          else state_d = mcst_pkg::S_KREQ;
      mcst_pkg::S_DECIDE: begin
        if (cmd_q.action == mcst_pkg::ACT_SUB_CLOSE && found_q && lim != '0)
          state_d = mcst_pkg::S_FREQ;
        else state_d = mcst_pkg::S_DONE;
      end
      mcst_pkg::S_FREQ:   state_d = mcst_pkg::S_FCHK;
      mcst_pkg::S_FCHK: begin
        if (fw_rd[DW-1 -: 64] == cmd_q.subflow_id)
          state_d = ((sl_q + 1'b1) < (SW+1)'(lim)) ? mcst_pkg::S_SREQ : mcst_pkg::S_DONE;
        else if ((sl_q + 1'b1) < (SW+1)'(lim)) state_d = mcst_pkg::S_FREQ;
        else state_d = mcst_pkg::S_DONE;
      end
      mcst_pkg::S_SREQ:   state_d = mcst_pkg::S_SMOVE;
      mcst_pkg::S_SMOVE:  state_d = ((sl_q + 1'b1) < (SW+1)'(lim)) ? mcst_pkg::S_SREQ
                                                                  : mcst_pkg::S_DONE;
      mcst_pkg::S_DONE:   state_d = mcst_pkg::S_IDLE;
      default:            state_d = mcst_pkg::S_IDLE;
    endcase
  end

  logic [EW-1:0] free_e;
  logic          free_ok;
  always_comb begin
    free_e = '0;
    free_ok = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_e = EW'(i);
        free_ok = 1'b1;
      end
    end
  end

  always_comb begin
    idx_d = idx_q; ent_d = ent_q; found_d = found_q; cnt_d = cnt_q;
    sl_d = sl_q; st_d = st_q; rc_d = rc_q;
    ew_we = 1'b0; ew_addr = idx_e; ew_wd = {cmd_q.conn_key, CW'(1)};
    fw_we = 1'b0; fw_addr = FW'({ent_q, sl_q[SW-1:0]}); fw_wd = new_flow;
    unique case (state_q)
      mcst_pkg::S_IDLE: begin
        idx_d = '0; found_d = 1'b0; sl_d = '0;
        st_d = mcst_pkg::ST_IGNORED; rc_d = '0;
      end
      mcst_pkg::S_KREQ: ew_addr = idx_e;
      mcst_pkg::S_KCHK: begin
        if (valid_q[idx_e] && ew_rd[64+CW-1 -: 64] == cmd_q.conn_key) begin
          found_d = 1'b1; ent_d = idx_e; cnt_d = ew_rd[CW-1:0];
        end
        idx_d = idx_q + 1'b1;
      end
      mcst_pkg::S_DECIDE: begin
        st_d = mcst_pkg::ST_OK; rc_d = '0;
        if (cmd_q.action == mcst_pkg::ACT_ESTABLISH) begin
          if (found_q) begin
            st_d = mcst_pkg::ST_EXISTS; rc_d = 4'(cnt_q);
          end else if (!free_ok) st_d = mcst_pkg::ST_FULL;
          else begin
            ew_we = 1'b1; ew_addr = free_e;
            fw_we = 1'b1; fw_addr = FW'({free_e, SW'(0)});
            rc_d = 4'd1;
          end
        end else if (!found_q) st_d = mcst_pkg::ST_MISSING;
        else if (cmd_q.action == mcst_pkg::ACT_SUB_EST) begin
          if (next_sl == '0) begin
            st_d = mcst_pkg::ST_LIST; rc_d = 4'(cnt_q);
          end else begin
            ew_we = 1'b1; ew_addr = ent_q;
            ew_wd = {cmd_q.conn_key, CW'(next_sl) + CW'(1)};
            fw_we = 1'b1; fw_addr = FW'({ent_q, next_sl});
            rc_d = 4'(CW'(next_sl) + CW'(1));
          end
        end else if (cmd_q.action == mcst_pkg::ACT_SUB_CLOSE) begin
          st_d = mcst_pkg::ST_NOFLOW; rc_d = 4'(cnt_q);
        end
      end
      mcst_pkg::S_FREQ: fw_addr = FW'({ent_q, sl_q[SW-1:0]});
      mcst_pkg::S_FCHK: begin
        if (fw_rd[DW-1 -: 64] == cmd_q.subflow_id) begin
          st_d = mcst_pkg::ST_OK; rc_d = 4'(cnt_q - 1'b1);
          ew_we = 1'b1; ew_addr = ent_q; ew_wd = {cmd_q.conn_key, cnt_q - 1'b1};
        end
        sl_d = sl_q + 1'b1;
      end
      mcst_pkg::S_SREQ: fw_addr = FW'({ent_q, sl_q[SW-1:0]});
      mcst_pkg::S_SMOVE: begin
        fw_we = 1'b1; fw_addr = FW'({ent_q, SW'(sl_q - 1'b1)}); fw_wd = fw_rd;
        sl_d = sl_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcst_pkg::S_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mcst_pkg::S_DECIDE) begin
        if (cmd_q.action == mcst_pkg::ACT_ESTABLISH && !found_q && free_ok)
          valid_q[free_e] <= 1'b1;
        if (cmd_q.action == mcst_pkg::ACT_CLOSE && found_q)
          valid_q[ent_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mcst_pkg::S_IDLE && start_i) cmd_q <= cmd_i;
    idx_q <= idx_d; ent_q <= ent_d; found_q <= found_d; cnt_q <= cnt_d;
    sl_q <= sl_d; st_q <= st_d; rc_q <= rc_d;
  end

  assign busy_o = (state_q != mcst_pkg::S_IDLE);
  assign done_o = (state_q == mcst_pkg::S_DONE);
  assign rsp_o  = '{status: st_q, subflow_count: rc_q};
endmodule
`default_nettype wire

// File: src/mcst_checker.sv
// Port-level checker for the subflow table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mcst_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           done_o,
  input wire mcst_pkg::rsp_t rsp_o
);
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o && !busy_o)
  `ASSERT_IMP(a_status_range, clk_i, rst_ni, done_o, rsp_o.status != 3'd7)
endmodule
bind multipath_connection_subflow_table mcst_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .rsp_o
);
`default_nettype wire

// File: dv/tb.sv
// Testbench for the connection subflow table: directed table plus random events.
`timescale 1ns / 1ps
module tb;
  localparam int NE = mcst_pkg::TableEntries;
  localparam int NS = mcst_pkg::MaxSubflows;
  localparam int CmdBits = $bits(mcst_pkg::cmd_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  mcst_pkg::cmd_t cmd_i = '0;
  logic busy_o, done_o;
  mcst_pkg::rsp_t rsp_o;

  int errors = 0;

  always #5 clk_i = ~clk_i;

  multipath_connection_subflow_table i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .cmd_i(cmd_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  // Shadow copy of the table; subflow slots hold only the handle since
  // ports and addresses never show up in a response word.
  bit          tbl_valid [NE];
  bit [63:0]   tbl_key   [NE];
  int unsigned tbl_count [NE];
  bit [63:0]   tbl_flow  [NE][NS];

  mcst_pkg::rsp_t pending_rsp[$];

  // Keys of sent establish words, reused so that random events hit stored state.
  bit [63:0] key_pool[$];

  function automatic mcst_pkg::rsp_t table_event(mcst_pkg::cmd_t c);
    mcst_pkg::rsp_t r;
    int e, f, lim, i, j;
    int unsigned nxt;
    r.status = mcst_pkg::ST_OK;
    r.subflow_count = '0;
    if (c.is_ipv6) begin
      r.status = mcst_pkg::ST_IGNORED;
      return r;
    end
    e = -1;
    for (i = 0; i < NE; i++)
      if (e < 0 && tbl_valid[i] && tbl_key[i] == c.conn_key) e = i;
    if (c.action == mcst_pkg::ACT_ESTABLISH) begin
      if (e >= 0) begin
        r.status = mcst_pkg::ST_EXISTS;
        r.subflow_count = 4'(tbl_count[e]);
      end else begin
        f = -1;
        for (i = 0; i < NE; i++)
          if (f < 0 && !tbl_valid[i]) f = i;
        if (f < 0) r.status = mcst_pkg::ST_FULL;
        else begin
          tbl_valid[f] = 1'b1;
          tbl_key[f] = c.conn_key;
          tbl_count[f] = 1;
          tbl_flow[f][0] = c.subflow_id;
          r.subflow_count = 4'd1;
        end
      end
    end else if (e < 0) begin
      r.status = mcst_pkg::ST_MISSING;
    end else if (c.action == mcst_pkg::ACT_SUB_EST) begin
      nxt = tbl_count[e] & (NS - 1);
      if (nxt == 0) begin
        r.status = mcst_pkg::ST_LIST;
        r.subflow_count = 4'(tbl_count[e]);
      end else begin
        tbl_flow[e][nxt] = c.subflow_id;
        tbl_count[e] = nxt + 1;
        r.subflow_count = 4'(nxt + 1);
      end
    end else if (c.action == mcst_pkg::ACT_CLOSE) begin
      tbl_valid[e] = 1'b0;
    end else begin
      lim = (tbl_count[e] < NS) ? tbl_count[e] : NS;
      i = lim;
      for (j = lim - 1; j >= 0; j--)
        if (tbl_flow[e][j] == c.subflow_id) i = j;
      if (i >= lim) begin
        r.status = mcst_pkg::ST_NOFLOW;
        r.subflow_count = 4'(tbl_count[e]);
      end else begin
        for (j = i + 1; j < lim; j++) tbl_flow[e][j-1] = tbl_flow[e][j];
        tbl_count[e] = tbl_count[e] - 1;
        r.subflow_count = 4'(tbl_count[e]);
      end
    end
    return r;
  endfunction

  function automatic mcst_pkg::cmd_t rand_word();
    mcst_pkg::cmd_t c;
    int e;
    c = CmdBits'({$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom});
    c.is_ipv6 = ($urandom_range(0, 19) == 0);
    // Mostly well-formed: pooled keys and small or stored handles.
    if (key_pool.size() > 0 && $urandom_range(0, 9) < 7)
      c.conn_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if ($urandom_range(0, 1)) c.conn_key = {62'd0, 2'($urandom)};
    if ($urandom_range(0, 3) != 0) c.subflow_id = {61'd0, 3'($urandom)};
    case ($urandom_range(0, 9))
      0, 1, 2: c.action = mcst_pkg::ACT_ESTABLISH;
      3, 4, 5: c.action = mcst_pkg::ACT_SUB_EST;
      6:       c.action = mcst_pkg::ACT_CLOSE;
      default: c.action = mcst_pkg::ACT_SUB_CLOSE;
    endcase
    if (c.action == mcst_pkg::ACT_SUB_CLOSE && $urandom_range(0, 1)) begin
      for (e = 0; e < NE; e++)
        if (tbl_valid[e] && tbl_key[e] == c.conn_key && tbl_count[e] > 0)
          c.subflow_id = tbl_flow[e][$urandom_range(0, (tbl_count[e] < NS ?
                                                         tbl_count[e] : NS) - 1)];
    end
    return c;
  endfunction

  // Present one word, hold it until accepted, then drop start.
  task automatic send_word(mcst_pkg::cmd_t c, bit has_fixed, mcst_pkg::rsp_t fixed);
    mcst_pkg::rsp_t p;
    @(negedge clk_i);
    cmd_i <= c;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    p = table_event(c);
    if (has_fixed && p != fixed) begin
      $display("%0t: table row mismatch expected %h actual predictor %h",
               $time, fixed, p);
      errors++;
    end
    pending_rsp.push_back(p);
    if (c.action == mcst_pkg::ACT_ESTABLISH && key_pool.size() < 96)
      key_pool.push_back(c.conn_key);
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  // Response checker.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, rsp_o);
        errors++;
      end else begin
        if (rsp_o.status !== pending_rsp[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_rsp[0].status, rsp_o.status);
          errors++;
        end
        if (rsp_o.subflow_count !== pending_rsp[0].subflow_count) begin
          $display("%0t: count expected %0d actual %0d", $time,
                   pending_rsp[0].subflow_count, rsp_o.subflow_count);
          errors++;
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  typedef struct {
    mcst_pkg::action_e act;
    bit                v6;
    bit [63:0]         key;
    bit [63:0]         sid;
    bit                fixed;
    mcst_pkg::status_e st;
    int                cnt;
  } row_t;

  localparam bit [63:0] KMAX = '1;

  // Directed table: extremes, every action, each status but ST_FULL.
  row_t rows[] = '{
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd5, 64'd1,  1'b1, mcst_pkg::ST_MISSING, 0},
    '{mcst_pkg::ACT_CLOSE,     1'b0, 64'd5, 64'd1,  1'b1, mcst_pkg::ST_MISSING, 0},
    '{mcst_pkg::ACT_SUB_CLOSE, 1'b0, 64'd5, 64'd1,  1'b1, mcst_pkg::ST_MISSING, 0},
    '{mcst_pkg::ACT_ESTABLISH, 1'b1, 64'd5, 64'd1,  1'b1, mcst_pkg::ST_IGNORED, 0},
    '{mcst_pkg::ACT_ESTABLISH, 1'b0, KMAX,  KMAX,   1'b1, mcst_pkg::ST_OK,      1},
    '{mcst_pkg::ACT_ESTABLISH, 1'b0, KMAX,  64'd3,  1'b1, mcst_pkg::ST_EXISTS,  1},
    '{mcst_pkg::ACT_ESTABLISH, 1'b0, 64'd0, 64'd0,  1'b1, mcst_pkg::ST_OK,      1},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd1,  1'b1, mcst_pkg::ST_OK,      2},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd2,  1'b1, mcst_pkg::ST_OK,      3},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd3,  1'b0, mcst_pkg::ST_OK,      0},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd4,  1'b0, mcst_pkg::ST_OK,      0},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd5,  1'b0, mcst_pkg::ST_OK,      0},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd6,  1'b0, mcst_pkg::ST_OK,      0},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, KMAX,   1'b1, mcst_pkg::ST_OK,      8},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, 64'd0, 64'd9,  1'b1, mcst_pkg::ST_LIST,    8},
    '{mcst_pkg::ACT_SUB_CLOSE, 1'b0, 64'd0, 64'd77, 1'b1, mcst_pkg::ST_NOFLOW,  8},
    '{mcst_pkg::ACT_SUB_CLOSE, 1'b0, 64'd0, 64'd0,  1'b1, mcst_pkg::ST_OK,      7},
    '{mcst_pkg::ACT_SUB_CLOSE, 1'b0, 64'd0, KMAX,   1'b1, mcst_pkg::ST_OK,      6},
    '{mcst_pkg::ACT_SUB_CLOSE, 1'b0, KMAX,  KMAX,   1'b1, mcst_pkg::ST_OK,      0},
    '{mcst_pkg::ACT_SUB_EST,   1'b0, KMAX,  64'd1,  1'b1, mcst_pkg::ST_LIST,    0},
    '{mcst_pkg::ACT_SUB_CLOSE, 1'b0, KMAX,  KMAX,   1'b1, mcst_pkg::ST_NOFLOW,  0},
    '{mcst_pkg::ACT_CLOSE,     1'b0, KMAX,  64'd0,  1'b1, mcst_pkg::ST_OK,      0},
    '{mcst_pkg::ACT_CLOSE,     1'b1, 64'd0, 64'd0,  1'b1, mcst_pkg::ST_IGNORED, 0}
  };

  initial begin
    mcst_pkg::cmd_t c;
    mcst_pkg::rsp_t fx;
    int n, gap;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      c = CmdBits'({$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom});
      c.action = rows[i].act;
      c.is_ipv6 = rows[i].v6;
      c.conn_key = rows[i].key;
      c.subflow_id = rows[i].sid;
      if (i == 4) begin
        c.rem_port = '1; c.loc_port = '1; c.rem_ip = '1; c.loc_ip = '1;
      end
      if (i == 6) begin
        c.rem_port = '0; c.loc_port = '0; c.rem_ip = '0; c.loc_ip = '0;
      end
      fx.status = rows[i].st;
      fx.subflow_count = 4'(rows[i].cnt);
      send_word(c, rows[i].fixed, fx);
    end

    // Fill the table to overflow, then drain part of it.
    for (n = 0; n <= NE; n++) begin
      c = rand_word();
      c.is_ipv6 = 1'b0;
      c.action = mcst_pkg::ACT_ESTABLISH;
      c.conn_key = 64'h1000 + n;
      send_word(c, 1'b0, '0);
    end
    for (n = 0; n < NE; n += 3) begin
      c = rand_word();
      c.is_ipv6 = 1'b0;
      c.action = mcst_pkg::ACT_CLOSE;
      c.conn_key = 64'h1000 + n;
      send_word(c, 1'b0, '0);
    end

    // Hold off until every response is back.
    while (pending_rsp.size() > 0) @(posedge clk_i);

    // Random bursts with random gaps.
    n = 0;
    while (n < 940) begin
      gap = $urandom_range(0, 3);
      for (int b = $urandom_range(1, 12); b > 0 && n < 940; b--) begin
        send_word(rand_word(), 1'b0, '0);
        n++;
      end
      if (gap != 0) repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (key_pool.size() >= 96) key_pool.delete();
    end

    while (pending_rsp.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // About 1050 words, gaps included, must finish before this timeout.
  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/mcst_pkg.sv
src/mcst_ram.sv
src/multipath_connection_subflow_table.sv
src/mcst_checker.sv
dv/tb.sv
